>>> rtl/xy_pad_cc_and_scale_note_unit_assert.svh
// assertion macros for the xy pad controller and note unit
// used by the top level, no other dependencies
`ifndef XY_PAD_CC_AND_SCALE_NOTE_UNIT_ASSERT_SVH
`define XY_PAD_CC_AND_SCALE_NOTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define XYSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xysc assertion failed");
`define XYSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xysc assertion failed");
`else
`define XYSC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define XYSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/xysc_pkg.sv
// shared types, constants and the scale step lookup for the xy pad note unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package xysc_pkg;

   typedef struct packed {
      logic est;
      logic fix;
   } pipe_en_type;

   localparam logic [1:0] CSR_SCALE  = 2'd0;
   localparam logic [1:0] CSR_ROOT   = 2'd1;
   localparam logic [1:0] CSR_OCTAVE = 2'd2;

   localparam logic [1:0] SCALE_RESET    = 2'd0;
   localparam logic [3:0] ROOT_RESET     = 4'd0;
   localparam logic [3:0] ROOT_COUNT     = 4'd12;
   localparam logic [3:0] OCTAVE_RESET   = 4'd4;
   localparam logic [3:0] OCTAVE_HIGHEST = 4'd8;
   localparam logic [6:0] CC_MAX         = 7'd127;
   localparam logic [7:0] NOTE_MAX       = 8'd127;
   localparam logic [4:0] OCTAVE_STEP    = 5'd12;

   localparam logic [3:0] STEP_TABLE [4][12] = '{
      '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11}
   };

   localparam logic [3:0] SCALE_STEPS [4] = '{4'd7, 4'd7, 4'd5, 4'd12};

   // semitone offset of a step index that spans two octaves of the scale
   function automatic logic [4:0] step_offset(input logic [1:0] sel, input logic [4:0] idx);
      logic [3:0] len;
      logic [4:0] rem;
      logic [4:0] oct_add;
      len = SCALE_STEPS[sel];
      if (idx >= {1'b0, len}) begin
         rem     = idx - {1'b0, len};
         oct_add = OCTAVE_STEP;
      end else begin
         rem     = idx;
         oct_add = 5'd0;
      end
      return oct_add + {1'b0, STEP_TABLE[sel][rem[3:0]]};
   endfunction

endpackage
`default_nettype wire

>>> rtl/xysc_cdiv.sv
// two-stage divide by a constant: reciprocal multiply, then one correction step
// depends on xysc_pkg
`timescale 1ns / 1ps
`default_nettype none
module xysc_cdiv import xysc_pkg::*; #(
   parameter int NUM_W   = 19,
   parameter int QUO_W   = 7,
   parameter int DIVISOR = 1023
) (
   input  wire logic               clock,
   input  wire pipe_en_type        stage_en,
   input  wire logic [NUM_W-1:0]   num,
   output logic      [QUO_W-1:0]   quo
);

   localparam int          SHIFT = 31;
   localparam int          PROD_W = NUM_W + 32;
   localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / DIVISOR);

   logic [PROD_W-1:0] prod;
   logic [QUO_W-1:0]  est_in;
   logic [QUO_W-1:0]  est_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  rem;
   logic [QUO_W-1:0]  quo_in;
   logic [QUO_W-1:0]  quo_ff;

   // estimate is exact or one low
   assign prod   = PROD_W'(num) * PROD_W'(RECIP);
   assign est_in = prod[SHIFT +: QUO_W];

   always_ff @(posedge clock) begin
      if (stage_en.est) begin
         est_ff <= est_in;
         num_ff <= num;
      end
   end

   assign rem    = num_ff - NUM_W'(est_ff) * NUM_W'(DIVISOR);
   assign quo_in = (rem >= NUM_W'(DIVISOR)) ? QUO_W'(est_ff + 1'b1) : est_ff;

   always_ff @(posedge clock) begin
      if (stage_en.fix) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

>>> rtl/xy_pad_cc_and_scale_note_unit.sv
// top level of the xy pad controller and scale-quantized note unit
// depends on xysc_pkg, xysc_cdiv and xy_pad_cc_and_scale_note_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none
// Takes one touch pair per request transfer and returns one response with
// two 0..127 controller values and a note quantized to the selected scale.
// The unit is a four-stage pipeline (scale, reciprocal multiply, correction,
// note sum and output register): a new pair can be taken every cycle while
// the response side does not stall, and the response is presented from the
// stage 4 output register. Each stage takes a new item whenever it is empty
// or the stage ahead moves, so gaps close up behind a stalled response; once
// all four stages hold an item, a stalled response stalls the request side
// as well. Registers must be written through the csr port only while no
// item is in flight; the unit itself does not enforce this.
module xy_pad_cc_and_scale_note_unit import xysc_pkg::*; #(
   parameter int PAD_EXTENT = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [11:0] req_pad_x,
   input  wire logic [11:0] req_pad_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [6:0]  rsp_cc_horizontal,
   output logic      [6:0]  rsp_cc_vertical,
   output logic      [6:0]  rsp_note_number,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_wdata
);

   localparam int SPAN = (PAD_EXTENT > 1) ? PAD_EXTENT - 1 : 1;

   // configuration registers
   logic [1:0] scale_ff;
   logic [3:0] root_ff;
   logic [3:0] octave_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         root_ff   <= ROOT_RESET;
         octave_ff <= OCTAVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE: begin
               scale_ff <= csr_wdata[1:0];
            end
            CSR_ROOT: begin
               root_ff <= (csr_wdata < ROOT_COUNT) ? csr_wdata : ROOT_RESET;
            end
            CSR_OCTAVE: begin
               octave_ff <= (csr_wdata <= OCTAVE_HIGHEST) ? csr_wdata : OCTAVE_RESET;
            end
            default: begin
            end
         endcase
      end
   end

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: range checks and numerators
   logic        x_over_in, y_over_in;
   logic [11:0] inv_in;
   logic [4:0]  total_in;
   logic [18:0] nx_in, ny_in;
   logic [16:0] ni_in;
   logic        s1_x_over_ff, s1_y_over_ff;
   logic [18:0] s1_nx_ff, s1_ny_ff;
   logic [16:0] s1_ni_ff;

   assign x_over_in = {1'b0, req_pad_x} >= 13'(PAD_EXTENT);
   assign y_over_in = {1'b0, req_pad_y} >= 13'(PAD_EXTENT);
   assign inv_in    = y_over_in ? 12'd0 : 12'(SPAN) - req_pad_y;
   assign total_in  = {SCALE_STEPS[scale_ff], 1'b0};
   assign nx_in     = ({req_pad_x, 7'd0}) - 19'(req_pad_x);
   assign ny_in     = ({req_pad_y, 7'd0}) - 19'(req_pad_y);
   assign ni_in     = 17'(inv_in) * 17'(total_in);

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_x_over_ff <= x_over_in;
         s1_y_over_ff <= y_over_in;
         s1_nx_ff     <= nx_in;
         s1_ny_ff     <= ny_in;
         s1_ni_ff     <= ni_in;
      end
   end

   // stages 2 and 3: constant divides
   pipe_en_type div_en;
   logic [6:0]  qx, qy;
   logic [4:0]  qi;
   logic        s2_x_over_ff, s2_y_over_ff, s3_x_over_ff, s3_y_over_ff;

   assign div_en.est = s2_ready;
   assign div_en.fix = s3_ready;

   xysc_cdiv #(.NUM_W(19), .QUO_W(7), .DIVISOR(SPAN)) u_div_x (
      .clock    (clock),
      .stage_en (div_en),
      .num      (s1_nx_ff),
      .quo      (qx)
   );

   xysc_cdiv #(.NUM_W(19), .QUO_W(7), .DIVISOR(SPAN)) u_div_y (
      .clock    (clock),
      .stage_en (div_en),
      .num      (s1_ny_ff),
      .quo      (qy)
   );

   xysc_cdiv #(.NUM_W(17), .QUO_W(5), .DIVISOR(PAD_EXTENT)) u_div_idx (
      .clock    (clock),
      .stage_en (div_en),
      .num      (s1_ni_ff),
      .quo      (qi)
   );

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_x_over_ff <= s1_x_over_ff;
         s2_y_over_ff <= s1_y_over_ff;
      end
      if (s3_ready) begin
         s3_x_over_ff <= s2_x_over_ff;
         s3_y_over_ff <= s2_y_over_ff;
      end
   end

   // stage 4: controller values and note sum
   logic [7:0] base_in;
   logic [7:0] note_in;
   logic [6:0] cc_h_ff, cc_v_ff, note_ff;

   assign base_in = {4'd0, root_ff} + {1'b0, octave_ff, 3'd0} + {2'd0, octave_ff, 2'd0};
   assign note_in = base_in + {3'd0, step_offset(scale_ff, qi)};

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         cc_h_ff <= s3_x_over_ff ? CC_MAX : qx;
         cc_v_ff <= s3_y_over_ff ? 7'd0 : CC_MAX - qy;
         note_ff <= (note_in > NOTE_MAX) ? CC_MAX : note_in[6:0];
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_cc_horizontal = cc_h_ff;
   assign rsp_cc_vertical   = cc_v_ff;
   assign rsp_note_number   = note_ff;

`include "xy_pad_cc_and_scale_note_unit_assert.svh"

   `XYSC_ASSERT_NOW(a_root_range, clock, reset, 1'b1, root_ff < ROOT_COUNT)
   `XYSC_ASSERT_NOW(a_octave_range, clock, reset, 1'b1, octave_ff <= OCTAVE_HIGHEST)
   `XYSC_ASSERT_NEXT(a_req_enters, clock, reset, req_valid && req_ready, s1_valid_ff)
   `XYSC_ASSERT_NEXT(a_rsp_holds, clock, reset, s4_valid_ff && !rsp_ready, s4_valid_ff)

endmodule
`default_nettype wire
